[hdl/lidar_pulse_start_detect_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the lidar pulse start detector
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIDAR_PULSE_START_DETECT_UNIT_ASSERT_SVH
`define LIDAR_PULSE_START_DETECT_UNIT_ASSERT_SVH

// A condition that must hold in the same cycle as its antecedent.
`define LPSD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its antecedent.
`define LPSD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lpsd_pkg.sv]
// ----------------------------------------------------------------------------
// Lidar pulse start detector package
// Register map, reset values and the classified-sample record.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsd_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int BIN_OUT_W  = 13;
    localparam int START_W    = 12;
    localparam int END_W      = 13;
    localparam int BINS_W     = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [START_W-1:0]         RST_WINDOW_START = 12'd7;
    localparam logic [END_W-1:0]           RST_WINDOW_END   = 13'd200;
    localparam logic signed [SAMPLE_W-1:0] RST_NOISE_THR    = -8'sd110;
    localparam logic signed [SAMPLE_W-1:0] RST_SAT_THR      = 8'sd127;
    localparam logic [BINS_W-1:0]          RST_LOOKBACK     = 8'd50;
    localparam logic [BINS_W-1:0]          RST_LOOKAHEAD    = 8'd7;

    localparam logic signed [SAMPLE_W-1:0]  PEAK_FLOOR = -8'sd125;
    localparam logic signed [BIN_OUT_W-1:0] NO_PEAK    = -13'sd1;

    typedef enum logic [2:0] {
        REG_WINDOW_START = 3'd0,
        REG_WINDOW_END   = 3'd1,
        REG_NOISE_THR    = 3'd2,
        REG_SAT_THR      = 3'd3,
        REG_LOOKBACK     = 3'd4,
        REG_LOOKAHEAD    = 3'd5
    } reg_idx_t;

    // One sample after classification by the front end.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic [BIN_OUT_W-1:0]       bin;
        logic                       in_window;
        logic                       above_noise;
        logic                       sat_hit;
    } class_item_t;

endpackage

`default_nettype wire

[hdl/lpsd_front.sv]
// ----------------------------------------------------------------------------
// Front end of the lidar pulse start detector
// Holds the configuration registers, counts bins and classifies each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_front #(
    parameter int MAX_BINS = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lpsd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lpsd_pkg::DATA_W-1:0]    pwdata,
    output logic      [lpsd_pkg::DATA_W-1:0]    prdata,
    output logic                                pready,
    // Sample stream
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lpsd_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire logic                           in_last,
    // Towards the queue
    output logic                                push,
    output lpsd_pkg::class_item_t               push_item,
    input  wire logic                           queue_full
);
    import lpsd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int CMP_W = (CNT_W > END_W) ? CNT_W : END_W;

    logic [START_W-1:0]         window_start_reg;
    logic [END_W-1:0]           window_end_reg;
    logic signed [SAMPLE_W-1:0] noise_thr_reg;
    logic signed [SAMPLE_W-1:0] sat_thr_reg;
    logic [BINS_W-1:0]          lookback_reg;
    logic [BINS_W-1:0]          lookahead_reg;

    logic [CNT_W-1:0] bin_reg;
    logic [CNT_W-1:0] bin_next;

    logic                       cfg_write;
    logic                       accept;
    logic                       counting;
    logic [START_W-1:0]         win_begin;
    logic [END_W-1:0]           ahead_sum;
    logic [END_W-1:0]           win_stop;
    logic [CMP_W-1:0]           bin_x;
    logic signed [SAMPLE_W-1:0] smp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= RST_WINDOW_START;
            window_end_reg   <= RST_WINDOW_END;
            noise_thr_reg    <= RST_NOISE_THR;
            sat_thr_reg      <= RST_SAT_THR;
            lookback_reg     <= RST_LOOKBACK;
            lookahead_reg    <= RST_LOOKAHEAD;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_WINDOW_START: window_start_reg <= pwdata[START_W-1:0];
                REG_WINDOW_END:   window_end_reg   <= pwdata[END_W-1:0];
                REG_NOISE_THR:    noise_thr_reg    <= pwdata[SAMPLE_W-1:0];
                REG_SAT_THR:      sat_thr_reg      <= pwdata[SAMPLE_W-1:0];
                REG_LOOKBACK:     lookback_reg     <= pwdata[BINS_W-1:0];
                REG_LOOKAHEAD:    lookahead_reg    <= pwdata[BINS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_WINDOW_START: prdata = DATA_W'(window_start_reg);
            REG_WINDOW_END:   prdata = DATA_W'(window_end_reg);
            REG_NOISE_THR:    prdata = DATA_W'($unsigned(noise_thr_reg));
            REG_SAT_THR:      prdata = DATA_W'($unsigned(sat_thr_reg));
            REG_LOOKBACK:     prdata = DATA_W'(lookback_reg);
            REG_LOOKAHEAD:    prdata = DATA_W'(lookahead_reg);
            default:          prdata = '0;
        endcase
    end

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign smp      = $signed(in_sample);

    // The counter stops at MAX_BINS; a sample counted there joins neither scan.
    assign counting  = (bin_reg < CNT_W'(MAX_BINS));
    assign bin_x     = CMP_W'(bin_reg);
    assign win_begin = (window_start_reg > START_W'(lookback_reg))
                     ? window_start_reg - START_W'(lookback_reg) : '0;
    assign ahead_sum = END_W'(window_start_reg) + END_W'(lookahead_reg);
    assign win_stop  = (ahead_sum > window_end_reg) ? window_end_reg : ahead_sum;

    always_comb
    begin
        push_item.sample      = smp;
        push_item.last        = in_last;
        push_item.bin         = BIN_OUT_W'(bin_reg);
        push_item.in_window   = counting && (bin_x >= CMP_W'(win_begin))
                              && (bin_x < CMP_W'(win_stop));
        push_item.above_noise = (smp > noise_thr_reg);
        push_item.sat_hit     = counting && (bin_x >= CMP_W'(window_start_reg))
                              && (bin_x < CMP_W'(window_end_reg))
                              && (smp >= sat_thr_reg);
    end

    assign push = accept;

    always_comb
    begin
        bin_next = bin_reg;
        if (accept)
        begin
            if (in_last)
            begin
                bin_next = '0;
            end
            else if (counting)
            begin
                bin_next = bin_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg <= '0;
        end
        else
        begin
            bin_reg <= bin_next;
        end
    end

endmodule

`default_nettype wire

[hdl/lpsd_queue.sv]
// ----------------------------------------------------------------------------
// Classified-sample queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire lpsd_pkg::class_item_t  push_item,
    output logic                        full,
    input  wire logic                   pop,
    output lpsd_pkg::class_item_t       head_item,
    output logic                        head_valid
);
    import lpsd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    class_item_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[hdl/lpsd_back.sv]
// ----------------------------------------------------------------------------
// Back end of the lidar pulse start detector
// Tracks the peak and saturation flag per waveform and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lpsd_pkg::class_item_t           head_item,
    input  wire logic                            head_valid,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [lpsd_pkg::BIN_OUT_W-1:0]       out_pulse_bin,
    output logic                                 out_pulse_found,
    output logic                                 out_saturated
);
    import lpsd_pkg::*;

    logic signed [SAMPLE_W-1:0] peak_value_reg;
    logic signed [SAMPLE_W-1:0] peak_value_next;
    logic [BIN_OUT_W-1:0]       peak_bin_reg;
    logic [BIN_OUT_W-1:0]       peak_bin_next;
    logic                       found_reg;
    logic                       found_next;
    logic                       stopped_reg;
    logic                       stopped_next;
    logic                       sat_reg;
    logic                       sat_next;

    logic                       out_valid_reg;
    logic [BIN_OUT_W-1:0]       out_bin_reg;
    logic                       out_found_reg;
    logic                       out_sat_reg;

    logic                       load_result;
    logic                       take_peak;

    // A last sample may only leave the queue when the result register is empty or is taken in the same cycle.
    assign pop = head_valid && (!head_item.last || !out_valid_reg || out_ready);
    assign load_result = pop && head_item.last;

    assign take_peak = !stopped_reg && head_item.in_window && head_item.above_noise
                     && (head_item.sample > peak_value_reg);

    always_comb
    begin
        peak_value_next = peak_value_reg;
        peak_bin_next   = peak_bin_reg;
        found_next      = found_reg;
        stopped_next    = stopped_reg;
        sat_next        = sat_reg || head_item.sat_hit;
        if (take_peak)
        begin
            peak_value_next = head_item.sample;
            peak_bin_next   = head_item.bin;
            found_next      = 1'b1;
        end
        // Once a peak exists, the first window sample not above noise ends the search.
        if (!stopped_reg && head_item.in_window && found_reg && !head_item.above_noise)
        begin
            stopped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_value_reg <= PEAK_FLOOR;
            peak_bin_reg   <= NO_PEAK;
            found_reg      <= 1'b0;
            stopped_reg    <= 1'b0;
            sat_reg        <= 1'b0;
        end
        else if (pop)
        begin
            if (head_item.last)
            begin
                peak_value_reg <= PEAK_FLOOR;
                peak_bin_reg   <= NO_PEAK;
                found_reg      <= 1'b0;
                stopped_reg    <= 1'b0;
                sat_reg        <= 1'b0;
            end
            else
            begin
                peak_value_reg <= peak_value_next;
                peak_bin_reg   <= peak_bin_next;
                found_reg      <= found_next;
                stopped_reg    <= stopped_next;
                sat_reg        <= sat_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_bin_reg   <= peak_bin_next;
            out_found_reg <= found_next;
            out_sat_reg   <= sat_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_pulse_bin   = out_bin_reg;
    assign out_pulse_found = out_found_reg;
    assign out_saturated   = out_sat_reg;

`include "lidar_pulse_start_detect_unit_assert.svh"

    `LPSD_ASSERT_SAME(a_no_overwrite, out_valid_reg && !out_ready, !load_result, "result overwritten before transaction")
    `LPSD_ASSERT_NEXT(a_clear_after_last, load_result, !found_reg && !stopped_reg && !sat_reg, "waveform state not cleared")
    `LPSD_ASSERT_SAME(a_stop_needs_peak, stopped_reg, found_reg && (peak_value_reg > PEAK_FLOOR), "search stopped without a peak")
    `LPSD_ASSERT_SAME(a_found_bin, !found_reg, peak_bin_reg == NO_PEAK, "peak bin set without a peak")

endmodule

`default_nettype wire

[hdl/lidar_pulse_start_detect_unit.sv]
// ----------------------------------------------------------------------------
// Lidar pulse start detector
// Finds the outgoing pulse peak and saturation in each lidar waveform.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata = sample, tlast = last_sample
// m_axis    out        tdata = pulse_bin, pulse_found, saturated
// apb       in/out     six configuration registers at 0x00 .. 0x14
//
// One sample is taken every cycle while the four-entry queue has room.
// A sample is written to a queue entry before the back end sees it; a result
// appears in the cycle after its last sample leaves the queue.
// Reset clears the bin counter, queue, peak state and the result valid flag.
// A stalled result holds back only last samples; others keep draining.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_pulse_start_detect_unit #(
    parameter int MAX_BINS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] sample
    input  wire logic        s_tlast,   // last_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [12:0] pulse_bin, [13] pulse_found,
                                        // [14] saturated, [15] zero
);
    import lpsd_pkg::*;

    logic                 push;
    class_item_t          push_item;
    logic                 queue_full;
    logic                 pop;
    class_item_t          head_item;
    logic                 head_valid;
    logic [BIN_OUT_W-1:0] pulse_bin;
    logic                 pulse_found;
    logic                 saturated;

    lpsd_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    lpsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid)
    );

    lpsd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_item       (head_item),
        .head_valid      (head_valid),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_pulse_bin   (pulse_bin),
        .out_pulse_found (pulse_found),
        .out_saturated   (saturated)
    );

    assign m_tdata = {1'b0, saturated, pulse_found, pulse_bin};

endmodule

`default_nettype wire
